// ----- hdl/qts_pkg.sv -----
// package: shared constants and codes of the two-stack queue
`timescale 1ns / 1ps
`default_nettype none
package qts_pkg;

  localparam int unsigned DEFAULT_DEPTH = 1024;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned STATUS_W      = 2;

  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QRY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

endpackage
`default_nettype wire

// ----- hdl/qts_mem.sv -----
// module: word store shared by both stacks, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module qts_mem #(
  parameter int unsigned DEPTH = qts_pkg::DEFAULT_DEPTH,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [AddrW-1:0]          waddr_i,
  input  wire logic [qts_pkg::WORD_W-1:0] wdata_i,
  input  wire logic                      re_i,
  input  wire logic [AddrW-1:0]          raddr_i,
  output logic      [qts_pkg::WORD_W-1:0] rdata_o
);

  logic [qts_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic [qts_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/qts_ctrl.sv -----
// module: command sequencer, stack counters, transfer loop and result register
`timescale 1ns / 1ps
`default_nettype none
module qts_ctrl #(
  parameter int unsigned DEPTH = qts_pkg::DEFAULT_DEPTH,
  localparam int unsigned AddrW = $clog2(DEPTH),
  localparam int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [qts_pkg::CMD_W-1:0]      cmd_i,
  input  wire logic signed [qts_pkg::WORD_W-1:0] value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [qts_pkg::STATUS_W-1:0]   status_o,
  output logic signed [qts_pkg::WORD_W-1:0]   data_out_o,
  output logic                               is_empty_o,
  output logic                               mem_we_o,
  output logic      [AddrW-1:0]              mem_waddr_o,
  output logic      [qts_pkg::WORD_W-1:0]     mem_wdata_o,
  output logic                               mem_re_o,
  output logic      [AddrW-1:0]              mem_raddr_o,
  input  wire logic [qts_pkg::WORD_W-1:0]     mem_rdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOVE = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);
  localparam logic [CntW-1:0] OneC   = CntW'(1);

  logic [1:0]                    state_q, state_d;
  logic [CntW-1:0]               low_q, low_d;
  logic [CntW-1:0]               high_q, high_d;
  logic                          pend_q, pend_d;
  logic                          out_valid_q, out_valid_d;
  logic [qts_pkg::STATUS_W-1:0]  status_q, status_d;
  logic [qts_pkg::WORD_W-1:0]    data_q, data_d;
  logic                          empty_q, empty_d;
  logic                          accept;
  logic                          both_empty;
  logic [CntW:0]                 total;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign both_empty = (low_q == '0) && (high_q == '0);
  assign total      = {1'b0, low_q} + {1'b0, high_q};

  always_comb begin
    state_d     = state_q;
    low_d       = low_q;
    high_d      = high_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    data_d      = data_q;
    empty_d     = empty_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = $unsigned(value_i);
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            qts_pkg::CMD_ENQ: begin
              out_valid_d = 1'b1;
              data_d      = '0;
              if (total >= {1'b0, DepthC}) begin
                status_d = qts_pkg::ST_OVERFLOW;
                empty_d  = both_empty;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = low_q[AddrW-1:0];
                low_d       = low_q + OneC;
                status_d    = qts_pkg::ST_OK;
                empty_d     = 1'b0;
              end
            end
            qts_pkg::CMD_DEQ: begin
              if (both_empty) begin
                out_valid_d = 1'b1;
                status_d    = qts_pkg::ST_UNDERFLOW;
                data_d      = '0;
                empty_d     = 1'b1;
              end else if (high_q != '0) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = AddrW'(DepthC - high_q);
                high_d      = high_q - OneC;
                state_d     = S_POP;
              end else begin
                pend_d  = 1'b0;
                state_d = S_MOVE;
              end
            end
            default: begin
              out_valid_d = 1'b1;
              status_d    = qts_pkg::ST_OK;
              data_d      = '0;
              empty_d     = both_empty;
            end
          endcase
        end
      end
      S_MOVE: begin
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = AddrW'(DepthC - OneC - high_q);
          mem_wdata_o = mem_rdata_i;
          high_d      = high_q + OneC;
        end
        if (low_q != '0) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AddrW'(low_q - OneC);
          low_d       = low_q - OneC;
          pend_d      = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = AddrW'(DepthC - high_q);
            high_d      = high_q - OneC;
            state_d     = S_POP;
          end
        end
      end
      S_POP: begin
        out_valid_d = 1'b1;
        status_d    = qts_pkg::ST_OK;
        data_d      = mem_rdata_i;
        empty_d     = both_empty;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      low_q       <= '0;
      high_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      low_q       <= low_d;
      high_q      <= high_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    data_q   <= data_d;
    empty_q  <= empty_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_out_o  = $signed(data_q);
  assign is_empty_o  = empty_q;

endmodule
`default_nettype wire

// ----- hdl/queue_from_two_stacks.sv -----
// top level: fifo queue made of two stacks in one shared word store
//
// usage: one word in (cmd_i, value_i) on in_valid_i / in_ready_o, one result
// word out (status_o, data_out_o, is_empty_o) on out_valid_o / out_ready_i.
// cmd enqueue pushes onto stack one at the bottom of the store; dequeue pops
// stack two at the top; query (and the unused code) only reports emptiness.
// enqueue, query and errors: result in the cycle after acceptance.
// dequeue with stack two holding words: the top word is read from the store
// in the pop state, then registered as the result. dequeue with stack two
// empty first moves all n words of stack one across, one per cycle through
// the store's single read and write ports, then pops stack two the same way.
// one word is in flight at a time.
// the result sits in an output register; a new word is taken in the cycle
// the previous result leaves, so a stalled receiver holds off the input.
// reset empties both stacks at once; store contents are not cleared and
// need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module queue_from_two_stacks #(
  parameter int unsigned DEPTH = qts_pkg::DEFAULT_DEPTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [qts_pkg::CMD_W-1:0]          cmd_i,
  input  wire logic signed [qts_pkg::WORD_W-1:0]  value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [qts_pkg::STATUS_W-1:0]       status_o,
  output logic signed [qts_pkg::WORD_W-1:0]       data_out_o,
  output logic                                   is_empty_o
);

  localparam int unsigned AddrW = $clog2(DEPTH);

  logic                       mem_we;
  logic [AddrW-1:0]           mem_waddr;
  logic [qts_pkg::WORD_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AddrW-1:0]           mem_raddr;
  logic [qts_pkg::WORD_W-1:0] mem_rdata;

  qts_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .data_out_o  (data_out_o),
    .is_empty_o  (is_empty_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  qts_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
`default_nettype wire

// ----- hdl/qts_chk.sv -----
// checker: port-level properties of the two-stack queue, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module qts_chk (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [qts_pkg::STATUS_W-1:0]       status_o,
  input wire logic signed [qts_pkg::WORD_W-1:0]  data_out_o,
  input wire logic                              is_empty_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_out_o) && $stable(status_o))
    else $error("result word changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != qts_pkg::ST_OK) |-> data_out_o == '0)
    else $error("error result carries data");

  a_under_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == qts_pkg::ST_UNDERFLOW) |-> is_empty_o)
    else $error("underflow reported on non-empty queue");

  a_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == qts_pkg::ST_OVERFLOW) |-> !is_empty_o)
    else $error("overflow reported on empty queue");

endmodule

bind queue_from_two_stacks qts_chk u_qts_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .data_out_o  (data_out_o),
  .is_empty_o  (is_empty_o)
);
`default_nettype wire
